// ===== hw/rtl/mefb_pkg.sv =====
// Shared types and constants for the market event feature builder.
package mefb_pkg;

    localparam int MAX_LOOKBACK_DEF = 128;
    localparam logic [7:0] LOOKBACK_RESET = 8'd100;
    localparam logic [19:0] PPM_SCALE = 20'd1000000;
    localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0000;

    // One classified event as queued between front and back
    typedef struct packed {
        logic [62:0] seq;
        logic [63:0] xtime;
        logic [63:0] age;
        logic [63:0] bid;
        logic [63:0] ask;
        logic [62:0] bsize;
        logic [62:0] asize;
        logic [63:0] pos;
        logic [63:0] mid;
        logic        ret_en;
        logic        ret_neg;
        logic [63:0] ret_mag;
        logic [63:0] ret_div;
        logic        imb_en;
        logic        imb_neg;
        logic [63:0] imb_mag;
        logic [63:0] imb_div;
    } mefb_item_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RET,
        BK_RET_WAIT,
        BK_IMB,
        BK_IMB_WAIT,
        BK_OUT
    } mefb_back_state_t;

endpackage

// ===== hw/rtl/mefb_div.sv =====
// Bit-serial 128/64 unsigned divider with ppm prescale and signed 64-bit saturation.
module mefb_div
    import mefb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] mag,
    input  logic        neg,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quot
);

    logic [127:0] num_reg, num_next;
    logic [63:0]  rem_reg, rem_next;
    logic [127:0] q_reg, q_next;
    logic [63:0]  dvs_reg, dvs_next;
    logic         neg_reg, neg_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [63:0]  r_sh;
    logic         carry;
    logic [64:0]  diff;

    assign r_sh  = {rem_reg[62:0], num_reg[127]};
    assign carry = rem_reg[63];
    assign diff  = {1'b0, r_sh} - {1'b0, dvs_reg};

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            // prescale: one 64x20 product
            num_next  = {64'd0, mag} * {108'd0, PPM_SCALE};
            rem_next  = '0;
            q_next    = '0;
            dvs_next  = divisor;
            neg_next  = neg;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[126:0], 1'b0};
            if (carry || !diff[64]) begin
                rem_next = diff[63:0];
                q_next   = {q_reg[126:0], 1'b1};
            end else begin
                rem_next = r_sh;
                q_next   = {q_reg[126:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd127) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;

    always_comb begin
        if (!neg_reg) begin
            quot = (q_reg[127:63] != '0) ? SAT_POS : q_reg[63:0];
        end else begin
            quot = (q_reg[127:64] != '0 || q_reg[63:0] > SAT_NEG) ? SAT_NEG
                 : (64'd0 - q_reg[63:0]);
        end
    end

endmodule

// ===== hw/rtl/mefb_front.sv =====
// Front end: accept events, form the midpoint, keep the ring and classify the divisions.
module mefb_front
    import mefb_pkg::*;
#(
    parameter int MAX_LOOKBACK = MAX_LOOKBACK_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [62:0] s_sequence_number,
    input  logic [63:0] s_exchange_time,
    input  logic [63:0] s_receive_time,
    input  logic [63:0] s_best_bid,
    input  logic [63:0] s_best_ask,
    input  logic [62:0] s_bid_size,
    input  logic [62:0] s_ask_size,
    input  logic [63:0] s_position,
    output logic        q_valid,
    input  logic        q_ready,
    output mefb_item_t  q_item
);

    localparam int AW = (MAX_LOOKBACK > 1) ? $clog2(MAX_LOOKBACK) : 1;
    localparam int CW = $clog2(MAX_LOOKBACK + 1);

    logic [63:0] ring [MAX_LOOKBACK];
    logic [7:0]  lookback_reg;
    logic [AW-1:0] slot_reg;
    logic [CW-1:0] fill_reg;
    logic        st_reg;     // stage 1 holds an item waiting for ring read
    logic        out_vld_reg;
    mefb_item_t  st_item_reg, out_item_reg;
    mefb_item_t  cls_item;
    logic        full_reg;
    logic [63:0] old_rd_reg;
    logic [CW-1:0] len;
    logic [63:0] mid, old;
    logic        s_fire, adv;
    logic [AW-1:0] slot_eff;
    logic [CW-1:0] fill_eff;
    logic [63:0] half_up, half_dn;
    logic [63:0] total;

    always_comb begin
        if (lookback_reg == 8'd0) begin
            len = CW'(1);
        end else if (32'(lookback_reg) > MAX_LOOKBACK) begin
            len = CW'(MAX_LOOKBACK);
        end else begin
            len = CW'(lookback_reg);
        end
    end

    assign adv    = !out_vld_reg || q_ready;
    assign s_ready = !st_reg;
    assign s_fire = s_valid && s_ready;

    assign half_dn = (s_best_bid - s_best_ask) >> 1;
    assign half_up = (s_best_ask - s_best_bid) >> 1;
    assign mid = ($signed(s_best_ask) < $signed(s_best_bid)) ? s_best_bid - half_dn
                                                            : s_best_bid + half_up;
    assign slot_eff = (CW'(slot_reg) >= len) ? '0 : slot_reg;
    assign fill_eff = (fill_reg > len) ? len : fill_reg;
    assign total = {1'b0, s_bid_size} + {1'b0, s_ask_size};

    // ring: one write and one registered read per transfer
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            old_rd_reg    <= ring[slot_eff];
            ring[slot_eff] <= mid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            full_reg              <= (fill_eff == len);
            st_item_reg.seq       <= s_sequence_number;
            st_item_reg.xtime     <= s_exchange_time;
            st_item_reg.age       <= s_receive_time - s_exchange_time;
            st_item_reg.bid       <= s_best_bid;
            st_item_reg.ask       <= s_best_ask;
            st_item_reg.bsize     <= s_bid_size;
            st_item_reg.asize     <= s_ask_size;
            st_item_reg.pos       <= s_position;
            st_item_reg.mid       <= mid;
            st_item_reg.ret_en    <= 1'b0;
            st_item_reg.ret_neg   <= 1'b0;
            st_item_reg.ret_mag   <= '0;
            st_item_reg.ret_div   <= '0;
            st_item_reg.imb_en    <= (total != '0);
            st_item_reg.imb_neg   <= (s_bid_size < s_ask_size);
            st_item_reg.imb_mag   <= (s_bid_size < s_ask_size)
                                     ? {1'b0, s_ask_size - s_bid_size}
                                     : {1'b0, s_bid_size - s_ask_size};
            st_item_reg.imb_div   <= total;
        end
    end

    assign old = old_rd_reg;

    always_comb begin
        cls_item         = st_item_reg;
        cls_item.ret_en  = full_reg && old != '0 && !old[63];
        cls_item.ret_neg = $signed(st_item_reg.mid) < $signed(old);
        cls_item.ret_mag = ($signed(st_item_reg.mid) < $signed(old))
                           ? old - st_item_reg.mid : st_item_reg.mid - old;
        cls_item.ret_div = old;
    end

    always_ff @(posedge aclk) begin
        if (st_reg && adv) begin
            out_item_reg <= cls_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lookback_reg <= LOOKBACK_RESET;
            slot_reg     <= '0;
            fill_reg     <= '0;
            st_reg       <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                lookback_reg <= cfg_wr_data;
                slot_reg     <= '0;
                fill_reg     <= '0;
            end else if (s_fire) begin
                slot_reg <= (CW'(slot_eff) + CW'(1) >= len) ? '0 : slot_eff + AW'(1);
                fill_reg <= (fill_eff < len) ? fill_eff + CW'(1) : fill_eff;
            end
            if (s_fire) begin
                st_reg <= 1'b1;
            end else if (st_reg && adv) begin
                st_reg <= 1'b0;
            end
            if (st_reg && adv) begin
                out_vld_reg <= 1'b1;
            end else if (q_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign q_valid = out_vld_reg;
    assign q_item  = out_item_reg;

endmodule

// ===== hw/rtl/mefb_queue.sv =====
// Two-entry queue between front and back.
module mefb_queue
    import mefb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  mefb_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output mefb_item_t out_item
);

    mefb_item_t mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;
    assign out_item = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr) begin
            mem[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

// ===== hw/rtl/mefb_back.sv =====
// Back end: run each enabled ppm division on the shared divider and present the result.
module mefb_back
    import mefb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  mefb_item_t  q_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [62:0] m_out_sequence,
    output logic [63:0] m_out_exchange_time,
    output logic [63:0] m_state_age,
    output logic [63:0] m_out_bid,
    output logic [63:0] m_out_ask,
    output logic [62:0] m_out_bid_size,
    output logic [62:0] m_out_ask_size,
    output logic [63:0] m_mid_move_ppm,
    output logic [20:0] m_size_skew_ppm,
    output logic [63:0] m_out_position
);

    mefb_back_state_t state_reg, state_next;
    mefb_item_t  it_reg;
    logic [63:0] ret_reg, imb_reg;
    logic        div_start, div_done;
    logic        div_neg;
    logic [63:0] div_mag, div_dvs, quot;
    logic        take;

    mefb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .mag     (div_mag),
        .neg     (div_neg),
        .divisor (div_dvs),
        .done    (div_done),
        .quot    (quot)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:     if (q_valid) state_next = BK_RET;
            BK_RET:      state_next = it_reg.ret_en ? BK_RET_WAIT : BK_IMB;
            BK_RET_WAIT: if (div_done) state_next = BK_IMB;
            BK_IMB:      state_next = it_reg.imb_en ? BK_IMB_WAIT : BK_OUT;
            BK_IMB_WAIT: if (div_done) state_next = BK_OUT;
            BK_OUT:      if (m_ready) state_next = BK_IDLE;
            default:     state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        take      = state_reg == BK_IDLE && q_valid;
        q_ready   = state_reg == BK_IDLE;
        m_valid   = state_reg == BK_OUT;
        div_start = (state_reg == BK_RET && it_reg.ret_en)
                 || (state_reg == BK_IMB && it_reg.imb_en);
        div_mag   = (state_reg == BK_RET) ? it_reg.ret_mag : it_reg.imb_mag;
        div_neg   = (state_reg == BK_RET) ? it_reg.ret_neg : it_reg.imb_neg;
        div_dvs   = (state_reg == BK_RET) ? it_reg.ret_div : it_reg.imb_div;
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            it_reg  <= q_item;
            ret_reg <= '0;
            imb_reg <= '0;
        end
        if (state_reg == BK_RET_WAIT && div_done) ret_reg <= quot;
        if (state_reg == BK_IMB_WAIT && div_done) imb_reg <= quot;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign m_out_sequence      = it_reg.seq;
    assign m_out_exchange_time = it_reg.xtime;
    assign m_state_age         = it_reg.age;
    assign m_out_bid           = it_reg.bid;
    assign m_out_ask           = it_reg.ask;
    assign m_out_bid_size      = it_reg.bsize;
    assign m_out_ask_size      = it_reg.asize;
    assign m_mid_move_ppm      = ret_reg;
    assign m_size_skew_ppm     = imb_reg[20:0];
    assign m_out_position      = it_reg.pos;

endmodule

// ===== hw/rtl/market_event_feature_builder.sv =====
// Top level of the market event feature builder.
//   channel  | direction | handshake           | content
//   s_*      | in        | s_valid / s_ready   | one market event
//   m_*      | out       | m_valid / m_ready   | one feature record
//   cfg_*    | in        | cfg_wr_en           | lookback_events
// When both divisions run, the back end does them one after the other as serial divisions
// on one shared divider and takes no new event until its result is taken; up to four
// further events wait in the front stages and the queue.
// Reset (aresetn low, synchronous) sets lookback to 100 and clears slot and fill count.
// Ring contents are not cleared; a stall on m_ready holds the back end and then the front.
module market_event_feature_builder
    import mefb_pkg::*;
#(
    parameter int MAX_LOOKBACK = MAX_LOOKBACK_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [62:0] s_sequence_number,
    input  logic [63:0] s_exchange_time,
    input  logic [63:0] s_receive_time,
    input  logic [63:0] s_best_bid,
    input  logic [63:0] s_best_ask,
    input  logic [62:0] s_bid_size,
    input  logic [62:0] s_ask_size,
    input  logic [63:0] s_position,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [62:0] m_out_sequence,
    output logic [63:0] m_out_exchange_time,
    output logic [63:0] m_state_age,
    output logic [63:0] m_out_bid,
    output logic [63:0] m_out_ask,
    output logic [62:0] m_out_bid_size,
    output logic [62:0] m_out_ask_size,
    output logic [63:0] m_mid_move_ppm,
    output logic [20:0] m_size_skew_ppm,
    output logic [63:0] m_out_position
);

    logic       f_valid, f_ready, b_valid, b_ready;
    mefb_item_t f_item, b_item;

    mefb_front #(.MAX_LOOKBACK(MAX_LOOKBACK)) u_front (
        .aclk, .aresetn, .cfg_wr_en, .cfg_wr_data,
        .s_valid, .s_ready, .s_sequence_number, .s_exchange_time, .s_receive_time,
        .s_best_bid, .s_best_ask, .s_bid_size, .s_ask_size, .s_position,
        .q_valid (f_valid), .q_ready (f_ready), .q_item (f_item)
    );

    mefb_queue u_queue (
        .aclk, .aresetn,
        .in_valid (f_valid), .in_ready (f_ready), .in_item (f_item),
        .out_valid (b_valid), .out_ready (b_ready), .out_item (b_item)
    );

    mefb_back u_back (
        .aclk, .aresetn,
        .q_valid (b_valid), .q_ready (b_ready), .q_item (b_item),
        .m_valid, .m_ready, .m_out_sequence, .m_out_exchange_time, .m_state_age,
        .m_out_bid, .m_out_ask, .m_out_bid_size, .m_out_ask_size, .m_mid_move_ppm,
        .m_size_skew_ppm, .m_out_position
    );

endmodule

// ===== hw/rtl/mefb_checker.sv =====
// Port-level checker for the feature builder, bound to the top level.
module mefb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_state_age,
    input logic [20:0] m_size_skew_ppm,
    input logic [63:0] m_mid_move_ppm
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mid_move_ppm) && $stable(m_state_age))
        else $error("result changed while stalled");

    a_imb_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_size_skew_ppm) <= 21'sd1000000
                  && $signed(m_size_skew_ppm) >= -21'sd1000000))
        else $error("imbalance out of range");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind market_event_feature_builder mefb_checker u_mefb_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_state_age, .m_size_skew_ppm, .m_mid_move_ppm
);

// ===== tb/market_event_feature_builder_test.sv =====
// Self-checking testbench for the market event feature builder: random and directed events.
module market_event_feature_builder_test
    import mefb_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        logic [62:0] seq;
        logic [63:0] xtime;
        logic [63:0] rtime;
        logic [63:0] bid;
        logic [63:0] ask;
        logic [62:0] bsize;
        logic [62:0] asize;
        logic [63:0] pos;
    } market_event_t;

    typedef struct {
        logic [62:0] seq;
        logic [63:0] xtime;
        logic [63:0] age;
        logic [63:0] bid;
        logic [63:0] ask;
        logic [62:0] bsize;
        logic [62:0] asize;
        logic [63:0] ret;
        logic [20:0] imb;
        logic [63:0] pos;
    } feature_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [62:0] s_sequence_number = '0;
    logic [63:0] s_exchange_time = '0;
    logic [63:0] s_receive_time = '0;
    logic [63:0] s_best_bid = '0;
    logic [63:0] s_best_ask = '0;
    logic [62:0] s_bid_size = '0;
    logic [62:0] s_ask_size = '0;
    logic [63:0] s_position = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [62:0] m_out_sequence;
    logic [63:0] m_out_exchange_time;
    logic [63:0] m_state_age;
    logic [63:0] m_out_bid;
    logic [63:0] m_out_ask;
    logic [62:0] m_out_bid_size;
    logic [62:0] m_out_ask_size;
    logic [63:0] m_mid_move_ppm;
    logic [20:0] m_size_skew_ppm;
    logic [63:0] m_out_position;

    market_event_t pending_events[$];
    feature_t expected_features[$];

    // predictor state
    logic [63:0] mid_history [MAX_LOOKBACK_DEF];
    int unsigned hist_slot = 0;
    int unsigned hist_fill = 0;
    logic [7:0] lookback = LOOKBACK_RESET;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int errors = 0;
    int events_sent = 0;
    int features_seen = 0;
    int quiet_cycles = 0;
    logic [63:0] price_level = 64'd1000000;

    market_event_feature_builder DUT (.*);

    always #10 aclk = ~aclk;

    function automatic logic [63:0] scale_ppm(logic [63:0] mag, bit neg, logic [63:0] divisor);
        logic [127:0] q;
        q = ({64'd0, mag} * {108'd0, PPM_SCALE}) / {64'd0, divisor};
        if (!neg)
            return (q > {64'd0, SAT_POS}) ? SAT_POS : q[63:0];
        return (q > {64'd0, SAT_NEG}) ? SAT_NEG : (64'd0 - q[63:0]);
    endfunction

    task automatic predict_features(input market_event_t ev);
        feature_t f;
        logic [63:0] mid, oldest, total, imb_full;
        int unsigned len;
        len = (lookback == 0) ? 1 : ((lookback > MAX_LOOKBACK_DEF) ? MAX_LOOKBACK_DEF : lookback);
        if ($signed(ev.ask) < $signed(ev.bid))
            mid = ev.bid - ((ev.bid - ev.ask) >> 1);
        else
            mid = ev.bid + ((ev.ask - ev.bid) >> 1);
        if (hist_slot >= len) hist_slot = 0;
        if (hist_fill > len) hist_fill = len;
        f.ret = '0;
        if (hist_fill == len) begin
            oldest = mid_history[hist_slot];
            if (oldest != 0 && !oldest[63]) begin
                if ($signed(mid) < $signed(oldest))
                    f.ret = scale_ppm(oldest - mid, 1'b1, oldest);
                else
                    f.ret = scale_ppm(mid - oldest, 1'b0, oldest);
            end
        end
        mid_history[hist_slot] = mid;
        hist_slot = (hist_slot + 1 >= len) ? 0 : hist_slot + 1;
        if (hist_fill < len) hist_fill++;
        total = {1'b0, ev.bsize} + {1'b0, ev.asize};
        imb_full = '0;
        if (total != 0) begin
            if (ev.bsize < ev.asize)
                imb_full = scale_ppm({1'b0, ev.asize - ev.bsize}, 1'b1, total);
            else
                imb_full = scale_ppm({1'b0, ev.bsize - ev.asize}, 1'b0, total);
        end
        f.imb = imb_full[20:0];
        f.seq = ev.seq;
        f.xtime = ev.xtime;
        f.age = ev.rtime - ev.xtime;
        f.bid = ev.bid;
        f.ask = ev.ask;
        f.bsize = ev.bsize;
        f.asize = ev.asize;
        f.pos = ev.pos;
        expected_features.push_back(f);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic market_event_t make_event(logic [63:0] bid, logic [63:0] ask,
                                                 logic [62:0] bsize, logic [62:0] asize);
        market_event_t ev;
        ev.seq = 63'(rand64());
        ev.xtime = rand64();
        ev.rtime = rand64();
        ev.pos = rand64();
        ev.bid = bid;
        ev.ask = ask;
        ev.bsize = bsize;
        ev.asize = asize;
        return ev;
    endfunction

    // mostly plausible quotes around a wandering price, some pure noise
    function automatic market_event_t random_event();
        market_event_t ev;
        logic [63:0] bid;
        logic [62:0] bs, as;
        int pick;
        pick = int'($urandom_range(99));
        if (pick < 15)
            return make_event(rand64(), rand64(), 63'(rand64()), 63'(rand64()));
        price_level = price_level + 64'($urandom_range(4000)) - 64'd2000;
        if (price_level[63] || price_level < 64'd100) price_level = 64'd1000000;
        bid = price_level + 64'($urandom_range(20));
        case ($urandom_range(9))
            0: begin
                bs = '0;
                as = '0;
            end
            1: begin
                bs = 63'(rand64());
                as = 63'(rand64());
            end
            default: begin
                bs = 63'($urandom_range(5000));
                as = 63'($urandom_range(5000));
            end
        endcase
        ev = make_event(bid, bid + 64'($urandom_range(50)), bs, as);
        if (pick < 20) ev.bid = bid + 64'($urandom_range(60));
        return ev;
    endfunction

    task automatic drain();
        do @(posedge aclk);
        while (pending_events.size() != 0 || s_valid || expected_features.size() != 0);
    endtask

    task automatic write_lookback(input logic [7:0] value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_data <= value;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        lookback = value;
        hist_slot = 0;
        hist_fill = 0;
    endtask

    task automatic push_random(input int count);
        repeat (count) pending_events.push_back(random_event());
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // driver: hold payload until transfer, then maybe idle
    always @(posedge aclk) begin
        market_event_t ev;
        if (s_valid && s_ready) begin
            predict_features({s_sequence_number, s_exchange_time, s_receive_time, s_best_bid,
                              s_best_ask, s_bid_size, s_ask_size, s_position});
            events_sent++;
        end
        if (aresetn && (!s_valid || s_ready)) begin
            if (pending_events.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                ev = pending_events.pop_front();
                s_sequence_number <= ev.seq;
                s_exchange_time <= ev.xtime;
                s_receive_time <= ev.rtime;
                s_best_bid <= ev.bid;
                s_best_ask <= ev.ask;
                s_bid_size <= ev.bsize;
                s_ask_size <= ev.asize;
                s_position <= ev.pos;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        feature_t f;
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        if (m_valid && m_ready) begin
            features_seen++;
            if (expected_features.size() == 0) begin
                $display("%0t unexpected result sequence %h", $time, m_out_sequence);
                errors++;
            end else begin
                f = expected_features.pop_front();
                check_field("out_sequence", f.seq, m_out_sequence);
                check_field("out_exchange_time", f.xtime, m_out_exchange_time);
                check_field("state_age", f.age, m_state_age);
                check_field("out_bid", f.bid, m_out_bid);
                check_field("out_ask", f.ask, m_out_ask);
                check_field("out_bid_size", f.bsize, m_out_bid_size);
                check_field("out_ask_size", f.asize, m_out_ask_size);
                check_field("mid_move_ppm", f.ret, m_mid_move_ppm);
                check_field("size_skew_ppm", f.imb, m_size_skew_ppm);
                check_field("out_position", f.pos, m_out_position);
            end
        end
    end

    // watchdog: count cycles with no transfer on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog expired with %0d results outstanding", $time,
                     expected_features.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [63:0] smax, smin;
        smax = SAT_POS;
        smin = SAT_NEG;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset lookback of 100, no idling
        push_random(180);

        // directed: lookback 2 compares each event with the one two back
        write_lookback(8'd2);
        pending_events.push_back(make_event(smax, smax, '0, '0));
        pending_events.push_back(make_event(smin, smin, '1, '0));
        pending_events.push_back(make_event(smax, smin, '0, '1));
        pending_events.push_back(make_event(smin, smax, '1, '1));
        pending_events.push_back(make_event(64'd1, 64'd1, 63'd1, 63'd0));
        pending_events.push_back(make_event(64'd0, 64'd1, 63'd0, 63'd1));
        // oldest tiny positive, huge moves: saturate upward
        pending_events.push_back(make_event(smax, smax, 63'd3, 63'd7));
        pending_events.push_back(make_event(64'd1, 64'd1, 63'd7, 63'd3));
        pending_events.push_back(make_event(smin, smin, 63'd5, 63'd5));
        pending_events.push_back(make_event(64'd2, 64'd2, 63'd1, 63'd2));
        // oldest negative, oldest zero
        pending_events.push_back(make_event(64'd500, 64'd600, 63'd9, 63'd1));
        pending_events.push_back(make_event(64'd0, 64'd0, 63'd1, 63'd9));
        pending_events.push_back(make_event(64'd450, 64'd451, 63'd100, 63'd300));
        pending_events.push_back(make_event(64'd700, 64'd700, 63'd300, 63'd100));
        // ordinary returns up and down
        pending_events.push_back(make_event(64'd400, 64'd402, '1, 63'd1));
        pending_events.push_back(make_event(64'd900, 64'd1000, 63'd1, '1));
        pending_events.push_back(make_event(-64'sd5, -64'sd2, 63'd0, 63'd0));

        write_lookback(8'd1);
        sender_idle_pct = 69;
        push_random(110);
        // hold the feed until everything has come out
        drain();
        push_random(110);

        write_lookback(8'd128);
        sender_idle_pct = 0;
        receiver_stall_pct = 69;
        push_random(250);

        write_lookback(8'd0);
        sender_idle_pct = 13;
        receiver_stall_pct = 13;
        push_random(90);
        write_lookback(8'd255);
        push_random(140);
        write_lookback(8'd7);
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        push_random(60);

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_features.size() != 0) begin
            $display("%0t %0d expected results never arrived", $time, expected_features.size());
            errors++;
        end
        $display("covered %0d events, %0d results, lookbacks 100/2/1/128/0/255/7", events_sent,
                 features_seen);
        $display("idle phases none, sender, receiver and both; %0d mismatches", errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
